// ===== hdl/iuc_pkg.sv =====
// ----------------------------------------------------------------------------
// iuc_pkg
// Shared types and codes for the interval union coverage block.
// ----------------------------------------------------------------------------
`default_nettype none

package iuc_pkg;

    localparam int VAL_W   = 63;
    localparam int COUNT_W = 64;

    // one stored range
    typedef struct packed {
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] lo;
    } range_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REVERSED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_APPEND,
        S_FINISH
    } state_t;

    // verdict of the merge unit on one stored range
    typedef struct packed {
        logic               drop;
        logic               covered;
        logic [VAL_W-1:0]   lo;
        logic [VAL_W-1:0]   hi;
        logic [COUNT_W-1:0] span;
    } merge_t;

endpackage

`default_nettype wire

// ===== hdl/iuc_cell.sv =====
// ----------------------------------------------------------------------------
// iuc_cell
// One slot of the range chain: shifts toward slot 0 or loads a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module iuc_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8
) (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire logic            load,
    input  wire logic [IW-1:0]   wp,
    input  iuc_pkg::range_t      load_data,
    input  iuc_pkg::range_t      right_data,
    output iuc_pkg::range_t      data
);

    iuc_pkg::range_t data_reg;
    iuc_pkg::range_t data_next;

    // load at the write slot wins over the shift
    always_comb
    begin
        data_next = data_reg;
        if (load && (wp == IW'(IDX)))
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== hdl/iuc_merge.sv =====
// ----------------------------------------------------------------------------
// iuc_merge
// Compares the range being inserted with one stored range and decides.
// ----------------------------------------------------------------------------
`default_nettype none

module iuc_merge (
    input  wire logic [iuc_pkg::VAL_W-1:0] lo,
    input  wire logic [iuc_pkg::VAL_W-1:0] hi,
    input  wire logic                      covered,
    input  iuc_pkg::range_t                stored,
    output iuc_pkg::merge_t                verdict
);

    logic [iuc_pkg::VAL_W-1:0] a;
    logic [iuc_pkg::VAL_W-1:0] b;

    assign a = stored.lo;
    assign b = stored.hi;

    always_comb
    begin
        verdict.drop    = 1'b0;
        verdict.covered = covered;
        verdict.lo      = lo;
        verdict.hi      = hi;
        verdict.span    = {1'b0, b} - {1'b0, a} + 64'd1;
        if (!covered)
        begin
            if (a >= lo && b <= hi)
            begin
                // stored range swallowed
                verdict.drop = 1'b1;
            end
            else if (lo >= a && hi <= b)
            begin
                // new range already covered
                verdict.covered = 1'b1;
            end
            else if (lo <= b && hi > b)
            begin
                verdict.lo   = a;
                verdict.drop = 1'b1;
            end
            else if (hi >= a && lo < a)
            begin
                verdict.hi   = b;
                verdict.drop = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/interval_union_coverage.sv =====
// ----------------------------------------------------------------------------
// interval_union_coverage
// Keeps disjoint ranges in a chain of cells and merges each new range.
// ----------------------------------------------------------------------------
// From accept to result a word passes the walk, append and finish states; a reversed
// range goes straight to finish. The walk pops one cell per cycle, and the finish
// state stalls while the previous result is not taken.
// A finished result waits in the output register while the next word is taken.
// Reset (rst_n low, async) clears range count, total and handshakes; cell
// contents are left as they are and never read before being written.
`default_nettype none

module interval_union_coverage #(
    parameter int MAX_RANGES = 256,
    localparam int CW    = $clog2(MAX_RANGES + 1),
    localparam int OUT_W = ((iuc_pkg::COUNT_W + CW + 2 + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [127:0]     s_tdata,  // range_low[62:0], range_high[125:63]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata   // covered_count, ranges_held, status
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int VW = iuc_pkg::VAL_W;

    iuc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  held_reg, held_next;
    logic [CW-1:0]  r_reg, r_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           cov_reg, cov_next;
    logic [VW-1:0]  lo_reg, lo_next;
    logic [VW-1:0]  hi_reg, hi_next;
    logic [63:0]    total_reg, total_next;
    iuc_pkg::status_t status_reg, status_next;
    logic           ov_reg, ov_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic           shift;
    logic           load;
    logic [CW-1:0]  wp;
    iuc_pkg::range_t load_data;
    iuc_pkg::range_t cells [MAX_RANGES];
    iuc_pkg::merge_t verdict;
    logic [VW-1:0]  in_lo;
    logic [VW-1:0]  in_hi;

    assign in_lo = s_tdata[62:0];
    assign in_hi = s_tdata[125:63];

    // chain of range cells
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        iuc_cell #(.IDX(i), .IW(IW)) u_cell (
            .clk        (clk),
            .shift      (shift),
            .load       (load),
            .wp         (wp[IW-1:0]),
            .load_data  (load_data),
            .right_data (cells[(i == MAX_RANGES - 1) ? i : i + 1]),
            .data       (cells[i])
        );
    end

    // decision on the word leaving slot 0
    iuc_merge u_merge (
        .lo      (lo_reg),
        .hi      (hi_reg),
        .covered (cov_reg),
        .stored  (cells[0]),
        .verdict (verdict)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        cov_next    = cov_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        total_next  = total_reg;
        status_next = status_reg;
        ov_next     = ov_reg && !m_tready;
        out_next    = out_reg;
        shift       = 1'b0;
        load        = 1'b0;
        wp          = '0;
        load_data   = cells[0];
        s_tready    = 1'b0;
        case (state_reg)
            iuc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    lo_next     = in_lo;
                    hi_next     = in_hi;
                    r_next      = held_reg;
                    k_next      = '0;
                    cov_next    = 1'b0;
                    status_next = iuc_pkg::ST_OK;
                    if (in_lo > in_hi)
                    begin
                        status_next = iuc_pkg::ST_REVERSED;
                        state_next  = iuc_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = iuc_pkg::S_WALK;
                    end
                end
            end
            iuc_pkg::S_WALK:
            begin
                if (r_reg == '0)
                begin
                    state_next = iuc_pkg::S_APPEND;
                end
                else
                begin
                    // pop slot 0; a kept word goes back behind the others
                    shift    = 1'b1;
                    wp       = r_reg - CW'(1) + k_reg;
                    load     = !verdict.drop;
                    lo_next  = verdict.lo;
                    hi_next  = verdict.hi;
                    cov_next = verdict.covered;
                    r_next   = r_reg - CW'(1);
                    if (verdict.drop)
                    begin
                        total_next = total_reg - verdict.span;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                    end
                end
            end
            iuc_pkg::S_APPEND:
            begin
                held_next  = k_reg;
                state_next = iuc_pkg::S_FINISH;
                if (!cov_reg)
                begin
                    if (k_reg < CW'(MAX_RANGES))
                    begin
                        load         = 1'b1;
                        wp           = k_reg;
                        load_data.lo = lo_reg;
                        load_data.hi = hi_reg;
                        held_next    = k_reg + CW'(1);
                        total_next   = total_reg + {1'b0, hi_reg} - {1'b0, lo_reg} + 64'd1;
                    end
                    else
                    begin
                        status_next = iuc_pkg::ST_FULL;
                    end
                end
            end
            iuc_pkg::S_FINISH:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    out_next   = OUT_W'({status_reg, held_reg, total_reg});
                    state_next = iuc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iuc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iuc_pkg::S_IDLE;
            held_reg  <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        k_reg      <= k_next;
        cov_reg    <= cov_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    // checks
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(MAX_RANGES))
        else $error("range count above table size");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iuc_pkg::S_WALK) |->
            ({1'b0, r_reg} + {1'b0, k_reg} <= {1'b0, held_reg}))
        else $error("walk counters exceed held ranges");

    a_reversed: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (in_lo > in_hi)) |=> (state_reg == iuc_pkg::S_FINISH))
        else $error("reversed range not short-cut");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == iuc_pkg::S_FINISH && state_reg == iuc_pkg::S_IDLE) |-> m_tvalid)
        else $error("result not presented after finish");

endmodule

`default_nettype wire
